@@ hw/rtl/tcw_pkg.sv @@
package tcw_pkg;

   localparam int CELL_W = 16;
   localparam int ATTR_W = 8;
   localparam int CHAR_W = 8;
   localparam int RGB_W  = 24;

   // word kinds on the request channel
   localparam logic [1:0] KIND_PUT  = 2'd0;
   localparam logic [1:0] KIND_SET  = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_FG     = 2'd0;
   localparam logic [1:0] CSR_BG     = 2'd1;
   localparam logic [1:0] CSR_CURSOR = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

   localparam logic [RGB_W-1:0] FG_RGB_RESET = 24'hFFFFFF;
   localparam logic [RGB_W-1:0] BG_RGB_RESET = 24'h000000;

   localparam int QUANT_BIAS = 42;
   localparam int QUANT_STEP = 85;

   // (v + bias) / step for an 8-bit channel, as three threshold compares
   function automatic logic [1:0] quantize_channel(input logic [7:0] v);
      logic [8:0] biased;
      logic [1:0] q;
      biased = {1'b0, v} + 9'(QUANT_BIAS);
      q = 2'(biased >= 9'(QUANT_STEP)) + 2'(biased >= 9'(2 * QUANT_STEP))
        + 2'(biased >= 9'(3 * QUANT_STEP));
      return q;
   endfunction

   function automatic logic [3:0] palette_index(input logic [RGB_W-1:0] rgb);
      logic [5:0] code;
      logic [3:0] idx;
      code = {quantize_channel(rgb[23:16]), quantize_channel(rgb[15:8]),
              quantize_channel(rgb[7:0])};
      unique case (code)
         6'h00: idx = 4'd0;
         6'h02: idx = 4'd1;
         6'h08: idx = 4'd2;
         6'h0A: idx = 4'd3;
         6'h20: idx = 4'd4;
         6'h22: idx = 4'd5;
         6'h24: idx = 4'd6;
         6'h2A: idx = 4'd7;
         6'h15: idx = 4'd8;
         6'h17: idx = 4'd9;
         6'h1D: idx = 4'd10;
         6'h1F: idx = 4'd11;
         6'h35: idx = 4'd12;
         6'h37: idx = 4'd13;
         6'h3D: idx = 4'd14;
         default: idx = 4'd15;
      endcase
      return idx;
   endfunction

endpackage

@@ hw/rtl/tcw_screen_ram.sv @@
module tcw_screen_ram import tcw_pkg::*; #(
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [CELL_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [CELL_W-1:0] rd_data
);

   logic [CELL_W-1:0] cells_ff [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= cells_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/tcw_ctrl.sv @@
module tcw_ctrl import tcw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   localparam int CELLS  = COLUMNS * ROWS,
   localparam int IDX_W  = $clog2(CELLS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_kind,
   input  logic [7:0]        req_char_code,
   input  logic [6:0]        req_new_col,
   input  logic [4:0]        req_new_row,
   input  logic [10:0]       req_cell_index,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [6:0]        rsp_cursor_col,
   output logic [4:0]        rsp_cursor_row,
   output logic [10:0]       rsp_cursor_index,
   output logic              rsp_cursor_shown,
   output logic [15:0]       rsp_cell_value,
   input  logic [ATTR_W-1:0] attr,
   input  logic              cursor_en,
   output logic              mem_wr_en,
   output logic [IDX_W-1:0]  mem_wr_addr,
   output logic [CELL_W-1:0] mem_wr_data,
   output logic              mem_rd_en,
   output logic [IDX_W-1:0]  mem_rd_addr,
   input  logic [CELL_W-1:0] mem_rd_data
);

   localparam int COL_W = $clog2(COLUMNS);
   localparam int ROW_W = $clog2(ROWS);
   localparam int CNT_W = $clog2(CELLS + 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCROLL,
      ST_FILL,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [IDX_W-1:0]  dst_ff, dst_in;
   logic              pend_ff, pend_in;
   logic              rd_cell_ff, rd_cell_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [6:0]        rsp_col_ff, rsp_col_in;
   logic [4:0]        rsp_row_ff, rsp_row_in;
   logic [10:0]       rsp_index_ff, rsp_index_in;
   logic              rsp_shown_ff, rsp_shown_in;
   logic [15:0]       rsp_cell_ff, rsp_cell_in;
   logic [IDX_W-1:0]  cur_addr;

   assign req_stall = (state_ff != ST_IDLE);
   assign cur_addr  = IDX_W'(32'(row_ff) * COLUMNS + 32'(col_ff));

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      ptr_in       = ptr_ff;
      dst_in       = dst_ff;
      pend_in      = pend_ff;
      rd_cell_in   = rd_cell_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_index_in = rsp_index_ff;
      rsp_shown_in = rsp_shown_ff;
      rsp_cell_in  = rsp_cell_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = cur_addr;
      mem_wr_data  = {attr, req_char_code};
      mem_rd_en    = 1'b0;
      mem_rd_addr  = IDX_W'(req_cell_index);

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = ptr_ff[IDX_W-1:0];
            mem_wr_data = BLANK_CELL;
            if (ptr_ff == CNT_W'(CELLS - 1)) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               rd_cell_in = 1'b0;
               state_in   = ST_DONE;
               unique case (req_kind)
                  KIND_PUT: begin
                     if (req_char_code == CHAR_CR) begin
                        col_in = '0;
                     end else begin
                        if (req_char_code != CHAR_LF) begin
                           mem_wr_en = 1'b1;
                        end
                        if (req_char_code == CHAR_LF || col_ff == COL_W'(COLUMNS - 1)) begin
                           col_in = '0;
                           if (row_ff == ROW_W'(ROWS - 1)) begin
                              ptr_in   = CNT_W'(COLUMNS);
                              pend_in  = 1'b0;
                              state_in = ST_SCROLL;
                           end else begin
                              row_in = row_ff + 1'b1;
                           end
                        end else begin
                           col_in = col_ff + 1'b1;
                        end
                     end
                  end
                  KIND_SET: begin
                     col_in = (32'(req_new_col) > COLUMNS - 1) ? COL_W'(COLUMNS - 1)
                                                              : COL_W'(req_new_col);
                     row_in = (32'(req_new_row) > ROWS - 1) ? ROW_W'(ROWS - 1)
                                                           : ROW_W'(req_new_row);
                  end
                  KIND_READ: begin
                     if (32'(req_cell_index) < CELLS) begin
                        mem_rd_en  = 1'b1;
                        rd_cell_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCROLL: begin
            // read one row ahead, write back in the next cycle
            if (pend_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = dst_ff;
               mem_wr_data = mem_rd_data;
            end
            if (ptr_ff != CNT_W'(CELLS)) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = ptr_ff[IDX_W-1:0];
               pend_in     = 1'b1;
               dst_in      = IDX_W'(ptr_ff - CNT_W'(COLUMNS));
               ptr_in      = ptr_ff + 1'b1;
            end else begin
               pend_in  = 1'b0;
               ptr_in   = CNT_W'((ROWS - 1) * COLUMNS);
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = ptr_ff[IDX_W-1:0];
            mem_wr_data = {attr, CHAR_SPACE};
            if (ptr_ff == CNT_W'(CELLS - 1)) begin
               ptr_in   = '0;
               state_in = ST_DONE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = 7'(col_ff);
               rsp_row_in   = 5'(row_ff);
               rsp_index_in = 11'(32'(row_ff) * COLUMNS + 32'(col_ff));
               rsp_shown_in = cursor_en;
               rsp_cell_in  = rd_cell_ff ? mem_rd_data : '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         col_ff       <= '0;
         row_ff       <= '0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         rd_cell_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         rd_cell_ff   <= rd_cell_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dst_ff       <= dst_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_index_ff <= rsp_index_in;
      rsp_shown_ff <= rsp_shown_in;
      rsp_cell_ff  <= rsp_cell_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cursor_col   = rsp_col_ff;
   assign rsp_cursor_row   = rsp_row_ff;
   assign rsp_cursor_index = rsp_index_ff;
   assign rsp_cursor_shown = rsp_shown_ff;
   assign rsp_cell_value   = rsp_cell_ff;

endmodule

@@ hw/rtl/text_console_writer_unit.sv @@
// Text console writer: a COLUMNS x ROWS screen of 16-bit cells (attribute in
// the high byte, character in the low byte) held in one single-port-write,
// registered-read RAM, plus a cursor. Each request word puts a character,
// sets the cursor (clamped to the screen) or reads a cell; each gives one
// response word with the cursor after the word. An ordinary word is first
// accepted and the cursor updated, then the response register is loaded,
// taking the RAM's registered read data. A line feed or line wrap on the
// bottom row scrolls the screen through the same RAM, one cell moved per
// cycle, then blanks the bottom row in the current colours. After reset the
// RAM is swept to white-on-black spaces with req_stall high; csr writes
// are taken throughout. The attribute is the 16-colour palette index of
// fg_rgb and bg_rgb as they stand when a character is put or the bottom
// row is blanked.
module text_console_writer_unit import tcw_pkg::*; #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_char_code,
   input  logic [6:0]  req_new_col,
   input  logic [4:0]  req_new_row,
   input  logic [10:0] req_cell_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_cursor_col,
   output logic [4:0]  rsp_cursor_row,
   output logic [10:0] rsp_cursor_index,
   output logic        rsp_cursor_shown,
   output logic [15:0] rsp_cell_value,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int IDX_W = $clog2(CELLS);

   // colours are kept as palette indexes, quantized at write time
   logic [3:0]        fg_idx_ff, fg_idx_in;
   logic [3:0]        bg_idx_ff, bg_idx_in;
   logic              cursor_en_ff, cursor_en_in;

   logic              mem_wr_en;
   logic [IDX_W-1:0]  mem_wr_addr;
   logic [CELL_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [IDX_W-1:0]  mem_rd_addr;
   logic [CELL_W-1:0] mem_rd_data;

   always_comb begin
      fg_idx_in    = fg_idx_ff;
      bg_idx_in    = bg_idx_ff;
      cursor_en_in = cursor_en_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FG:     fg_idx_in    = palette_index(csr_data);
            CSR_BG:     bg_idx_in    = palette_index(csr_data);
            CSR_CURSOR: cursor_en_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_idx_ff    <= palette_index(FG_RGB_RESET);
         bg_idx_ff    <= palette_index(BG_RGB_RESET);
         cursor_en_ff <= 1'b1;
      end else begin
         fg_idx_ff    <= fg_idx_in;
         bg_idx_ff    <= bg_idx_in;
         cursor_en_ff <= cursor_en_in;
      end
   end

   tcw_ctrl #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_char_code    (req_char_code),
      .req_new_col      (req_new_col),
      .req_new_row      (req_new_row),
      .req_cell_index   (req_cell_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cursor_col   (rsp_cursor_col),
      .rsp_cursor_row   (rsp_cursor_row),
      .rsp_cursor_index (rsp_cursor_index),
      .rsp_cursor_shown (rsp_cursor_shown),
      .rsp_cell_value   (rsp_cell_value),
      .attr             ({bg_idx_ff, fg_idx_ff}),
      .cursor_en        (cursor_en_ff),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data),
      .mem_rd_en        (mem_rd_en),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_data      (mem_rd_data)
   );

   tcw_screen_ram #(
      .DEPTH  (CELLS),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

@@ hw/rtl/tcw_checker.sv @@
module tcw_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [6:0]  rsp_cursor_col,
   input logic [4:0]  rsp_cursor_row,
   input logic [10:0] rsp_cursor_index,
   input logic        rsp_cursor_shown,
   input logic [15:0] rsp_cell_value
);

   // the screen sweep follows every reset
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("request taken during screen clear");

   // one word at a time: busy right after an accepted word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second word taken before response");

   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_cursor_col) < COLUMNS) && (32'(rsp_cursor_row) < ROWS))
      else $error("cursor off screen");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_cursor_col)
         && $stable(rsp_cursor_row) && $stable(rsp_cursor_index)
         && $stable(rsp_cursor_shown) && $stable(rsp_cell_value))
      else $error("stalled response word changed");

endmodule

bind text_console_writer_unit tcw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcw_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_cursor_col   (rsp_cursor_col),
   .rsp_cursor_row   (rsp_cursor_row),
   .rsp_cursor_index (rsp_cursor_index),
   .rsp_cursor_shown (rsp_cursor_shown),
   .rsp_cell_value   (rsp_cell_value)
);
